// ===== rtl/dl2_pkg.sv =====
`default_nettype none
package dl2_pkg;

    localparam int FRACTION_BITS_DEF        = 50;
    localparam int SQUARE_FRACTION_BITS_DEF = 62;

    localparam int MANT_W  = 52;
    localparam int EXP_W   = 11;
    localparam int BIAS    = 1023;
    localparam int SPLIT_W = 32;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES   = 11'h7FF;
    localparam logic [63:0]      NEG_INF_BITS   = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0]      CANON_NAN_BITS = 64'h7FF8_0000_0000_0000;

    // side information that travels with each beat through the pipeline
    typedef struct packed {
        logic              spec;
        logic [63:0]       spec_bits;
        logic [EXP_W-1:0]  ef;
    } t_side;

endpackage
`default_nettype wire

// ===== rtl/double_log2_by_squaring_unit.sv =====
// double_log2_by_squaring_unit: log2 of an IEEE-754 double, raw bits in and out
//
// input channel: i_valid / o_ready with i_value_bits; a beat moves when both
// are high. output channel: o_valid / i_ready with o_log_bits.
// zero gives minus infinity, negatives give the canonical NaN, NaN and plus
// infinity pass through; everything else goes through repeated squaring.
// throughput: one beat per cycle while the output is not stalled. stages: one
// decode stage, two stages per squaring (partial products, then sum and
// halve) and four stages of normalize and round.
// the pipeline advances as a whole: when o_valid is high and i_ready is low
// every stage holds and o_ready drops, so nothing is lost or repeated;
// bubbles inside the pipe keep their place.
// reset (i_rst_n low, synchronous) clears all valid bits; no clearing pass.
`default_nettype none
module double_log2_by_squaring_unit #(
    parameter int FRACTION_BITS        = dl2_pkg::FRACTION_BITS_DEF,
    parameter int SQUARE_FRACTION_BITS = dl2_pkg::SQUARE_FRACTION_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [63:0]  i_value_bits,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [63:0]       o_log_bits
);

    localparam int W  = SQUARE_FRACTION_BITS + 1;
    localparam int MW = dl2_pkg::MANT_W;

    logic                   w_en;
    logic                   w_sign;
    logic [dl2_pkg::EXP_W-1:0] w_ef;
    logic [MW-1:0]          w_mant;
    dl2_pkg::t_side         n0_side;
    logic [W-1:0]           n0_y;

    logic                   r0_vld;
    logic [W-1:0]           r0_y;
    dl2_pkg::t_side         r0_side;

    logic                   s_vld  [0:FRACTION_BITS];
    logic [W-1:0]           s_y    [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] s_f  [0:FRACTION_BITS];
    dl2_pkg::t_side         s_side [0:FRACTION_BITS];

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_sign = i_value_bits[63];
    assign w_ef   = i_value_bits[62:52];
    assign w_mant = i_value_bits[MW-1:0];
    assign n0_y   = W'({1'b1, w_mant}) << (SQUARE_FRACTION_BITS - MW);

    always_comb begin
        n0_side.ef        = w_ef;
        n0_side.spec      = 1'b1;
        n0_side.spec_bits = i_value_bits;
        if (w_ef == '0 && w_mant == '0) begin
            n0_side.spec_bits = dl2_pkg::NEG_INF_BITS;
        end else if (w_sign) begin
            n0_side.spec_bits = dl2_pkg::CANON_NAN_BITS;
        end else if (w_ef != dl2_pkg::EXP_ALL_ONES) begin
            n0_side.spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_y    <= n0_y;
            r0_side <= n0_side;
        end
    end

    assign s_vld[0]  = r0_vld;
    assign s_y[0]    = r0_y;
    assign s_f[0]    = '0;
    assign s_side[0] = r0_side;

    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_sq
        dl2_sq_stage #(
            .FRACTION_BITS        (FRACTION_BITS),
            .SQUARE_FRACTION_BITS (SQUARE_FRACTION_BITS)
        ) u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (s_vld[g]),
            .i_y     (s_y[g]),
            .i_f     (s_f[g]),
            .i_side  (s_side[g]),
            .o_vld   (s_vld[g+1]),
            .o_y     (s_y[g+1]),
            .o_f     (s_f[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    dl2_pack #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_vld[FRACTION_BITS]),
        .i_f     (s_f[FRACTION_BITS]),
        .i_side  (s_side[FRACTION_BITS]),
        .o_vld   (o_valid),
        .o_bits  (o_log_bits)
    );

endmodule
`default_nettype wire

// ===== rtl/dl2_sq_stage.sv =====
`default_nettype none
module dl2_sq_stage #(
    parameter int FRACTION_BITS        = dl2_pkg::FRACTION_BITS_DEF,
    parameter int SQUARE_FRACTION_BITS = dl2_pkg::SQUARE_FRACTION_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_vld,
    input  wire logic [SQUARE_FRACTION_BITS:0]         i_y,
    input  wire logic [FRACTION_BITS-1:0]              i_f,
    input  wire dl2_pkg::t_side                        i_side,
    output logic                                       o_vld,
    output logic [SQUARE_FRACTION_BITS:0]              o_y,
    output logic [FRACTION_BITS-1:0]                   o_f,
    output dl2_pkg::t_side                             o_side
);

    localparam int W  = SQUARE_FRACTION_BITS + 1;
    localparam int LW = dl2_pkg::SPLIT_W;
    localparam int HW = W - LW;
    localparam int SW = 2 * W;

    logic [HW-1:0]      w_yh;
    logic [LW-1:0]      w_yl;
    logic [2*HW-1:0]    n_hh;
    logic [HW+LW-1:0]   n_hl;
    logic [2*LW-1:0]    n_ll;

    logic               r_a_vld;
    logic [2*HW-1:0]    r_hh;
    logic [HW+LW-1:0]   r_hl;
    logic [2*LW-1:0]    r_ll;
    logic [FRACTION_BITS-1:0] r_a_f;
    dl2_pkg::t_side     r_a_side;

    logic [SW-1:0]      w_sq;
    logic [W:0]         w_t;
    logic [W-1:0]       n_y;
    logic [FRACTION_BITS-1:0] n_f;

    logic               r_b_vld;
    logic [W-1:0]       r_b_y;
    logic [FRACTION_BITS-1:0] r_b_f;
    dl2_pkg::t_side     r_b_side;

    // partial products of the square
    assign w_yh = i_y[W-1:LW];
    assign w_yl = i_y[LW-1:0];
    assign n_hh = (2*HW)'(w_yh) * (2*HW)'(w_yh);
    assign n_hl = (HW+LW)'(w_yh) * (HW+LW)'(w_yl);
    assign n_ll = (2*LW)'(w_yl) * (2*LW)'(w_yl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh     <= n_hh;
            r_hl     <= n_hl;
            r_ll     <= n_ll;
            r_a_f    <= i_f;
            r_a_side <= i_side;
        end
    end

    // sum, truncate, and halve when the square reached two
    assign w_sq = (SW'(r_hh) << (2*LW)) + (SW'(r_hl) << (LW+1)) + SW'(r_ll);
    assign w_t  = w_sq[SW-1:SQUARE_FRACTION_BITS];
    assign n_y  = w_t[W] ? w_t[W:1] : w_t[W-1:0];
    assign n_f  = {r_a_f[FRACTION_BITS-2:0], w_t[W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_y    <= n_y;
            r_b_f    <= n_f;
            r_b_side <= r_a_side;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_y    = r_b_y;
    assign o_f    = r_b_f;
    assign o_side = r_b_side;

endmodule
`default_nettype wire

// ===== rtl/dl2_pack.sv =====
`default_nettype none
module dl2_pack #(
    parameter int FRACTION_BITS = dl2_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire logic [FRACTION_BITS-1:0]   i_f,
    input  wire dl2_pkg::t_side             i_side,
    output logic                            o_vld,
    output logic [63:0]                     o_bits
);

    localparam int EW  = dl2_pkg::EXP_W;
    localparam int M   = FRACTION_BITS + EW;
    localparam int LZW = $clog2(M);
    localparam int KW  = dl2_pkg::MANT_W + 1;

    localparam logic [EW-1:0] BIAS_E = EW'(dl2_pkg::BIAS);
    localparam logic [EW-1:0] EXP_TOP = EW'(dl2_pkg::BIAS + M - 1 - FRACTION_BITS);

    // stage 1: fixed-point magnitude of e + f
    logic                   n1_neg;
    logic [EW-1:0]          n1_a;
    logic [FRACTION_BITS-1:0] n1_b;
    logic [M-1:0]           n1_mag;
    dl2_pkg::t_side         n1_side;

    logic                   r1_vld;
    logic                   r1_neg;
    logic [M-1:0]           r1_mag;
    dl2_pkg::t_side         r1_side;

    always_comb begin
        n1_neg  = i_side.ef < BIAS_E;
        n1_side = i_side;
        if (!n1_neg) begin
            n1_a = i_side.ef - BIAS_E;
            n1_b = i_f;
        end else if (i_f == '0) begin
            n1_a = BIAS_E - i_side.ef;
            n1_b = '0;
        end else begin
            n1_a = BIAS_E - i_side.ef - EW'(1);
            n1_b = '0 - i_f;
        end
        n1_mag = {n1_a, n1_b};
        // exact one gives plus zero
        if (!i_side.spec && n1_mag == '0) begin
            n1_side.spec      = 1'b1;
            n1_side.spec_bits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= n1_neg;
            r1_mag  <= n1_mag;
            r1_side <= n1_side;
        end
    end

    // stage 2: leading zero count
    logic [LZW-1:0]         n2_lz;
    logic                   r2_vld;
    logic                   r2_neg;
    logic [M-1:0]           r2_mag;
    logic [LZW-1:0]         r2_lz;
    dl2_pkg::t_side         r2_side;

    always_comb begin
        n2_lz = '0;
        for (int i = 0; i < M; i++) begin
            if (r1_mag[i]) begin
                n2_lz = LZW'(M - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_neg  <= r1_neg;
            r2_mag  <= r1_mag;
            r2_lz   <= n2_lz;
            r2_side <= r1_side;
        end
    end

    // stage 3: normalize
    logic                   r3_vld;
    logic                   r3_neg;
    logic [M-1:0]           r3_norm;
    logic [EW-1:0]          r3_exp;
    dl2_pkg::t_side         r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_neg  <= r2_neg;
            r3_norm <= r2_mag << r2_lz;
            r3_exp  <= EXP_TOP - EW'(r2_lz);
            r3_side <= r2_side;
        end
    end

    // stage 4: round to nearest even and pack
    logic [M+KW-1:0]        w_ext;
    logic [KW-1:0]          w_kept;
    logic                   w_guard;
    logic                   w_sticky;
    logic                   w_up;
    logic [KW:0]            w_sum;
    logic [EW-1:0]          w_exp;
    logic [63:0]            n4_bits;

    logic                   r4_vld;
    logic [63:0]            r4_bits;

    assign w_ext    = {r3_norm, {KW{1'b0}}};
    assign w_kept   = w_ext[M+KW-1 -: KW];
    assign w_guard  = w_ext[M-1];
    assign w_sticky = |w_ext[M-2:0];
    assign w_up     = w_guard && (w_sticky || w_kept[0]);
    assign w_sum    = {1'b0, w_kept} + (KW+1)'(w_up);
    assign w_exp    = r3_exp + EW'(w_sum[KW]);
    assign n4_bits  = r3_side.spec ? r3_side.spec_bits
                                   : {r3_neg, w_exp, w_sum[dl2_pkg::MANT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_bits <= n4_bits;
        end
    end

    assign o_vld  = r4_vld;
    assign o_bits = r4_bits;

`ifndef NO_ASSERTIONS
    a_norm_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld && !r3_side.spec |-> r3_norm[M-1])
        else $error("normalized magnitude lost its leading one");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld && !r3_side.spec |-> r3_exp != '0 && r3_exp != dl2_pkg::EXP_ALL_ONES)
        else $error("result exponent out of normal range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r4_bits) && $stable(r3_norm))
        else $error("pipeline moved while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vld)
        else $error("valid beat right after reset");
`endif

endmodule
`default_nettype wire

// ===== tb/double_log2_by_squaring_unit_test.sv =====
`timescale 1ns / 100ps
module double_log2_by_squaring_unit_test;

    localparam int FRAC_N = dl2_pkg::FRACTION_BITS_DEF;
    localparam int SQ_N   = dl2_pkg::SQUARE_FRACTION_BITS_DEF;
    localparam int LATENCY = 2 * FRAC_N + 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_value_bits = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_log_bits;

    logic [63:0] arg_queue[$];
    logic [63:0] log_expected[$];
    int          errors = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_off = 0;
    int          rx_beats = 0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    bit          stall_done = 1'b0;

    double_log2_by_squaring_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_value_bits(i_value_bits), .o_valid(o_valid), .i_ready(i_ready),
        .o_log_bits(o_log_bits)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] log2_of(logic [63:0] v);
        logic [10:0]  ef;
        logic [51:0]  mant;
        int           e, p, sh;
        logic [63:0]  y, f, a, b, kept, rem, half;
        logic [127:0] prod, mag;
        logic         neg;
        ef = v[62:52];
        mant = v[51:0];
        if (ef == 0 && mant == 0) return dl2_pkg::NEG_INF_BITS;
        if (v[63]) return dl2_pkg::CANON_NAN_BITS;
        if (ef == dl2_pkg::EXP_ALL_ONES) return v;
        e = int'(ef) - dl2_pkg::BIAS;
        y = (64'd1 << SQ_N) | (64'(mant) << (SQ_N - 52));
        f = 0;
        for (int i = 0; i < FRAC_N; i++) begin
            prod = 128'(y) * 128'(y);
            y = 64'(prod >> SQ_N);
            f = f << 1;
            if (y >= (64'd1 << (SQ_N + 1))) begin
                y = y >> 1;
                f[0] = 1'b1;
            end
        end
        if (e >= 0) begin
            neg = 0; a = 64'(e); b = f;
        end else begin
            neg = 1;
            if (f == 0) begin
                a = 64'(-e); b = 0;
            end else begin
                a = 64'(-e - 1); b = (64'd1 << FRAC_N) - f;
            end
        end
        if (a == 0 && b == 0) return 64'd0;
        mag = (128'(a) << FRAC_N) | 128'(b);
        p = 0;
        for (int i = 0; i < 128; i++) if (mag[i]) p = i;
        if (p <= 52) begin
            kept = 64'(mag << (52 - p));
        end else begin
            sh = p - 52;
            kept = 64'(mag >> sh) & ((64'd1 << 53) - 1);
            rem = 64'(mag) & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0])) kept++;
            if (kept == (64'd1 << 53)) begin
                kept = kept >> 1; p++;
            end
        end
        return {neg, 11'(p - FRAC_N + dl2_pkg::BIAS), kept[51:0]};
    endfunction

    function automatic logic [63:0] random_arg();
        logic [63:0] v;
        int          kind;
        v = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            0: v[63] = 1'b1;
            1: v[62:52] = 11'(dl2_pkg::BIAS + $urandom_range(0, 3) - 2);
            2: v[62:52] = 11'($urandom_range(0, 2));
            3: v[62:52] = 11'($urandom_range(2044, 2047));
            4: v[51:0] = 52'($urandom_range(0, 3));
            default: v[63] = 1'b0;
        endcase
        return v;
    endfunction

    // beats taken at the rising edge
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_valid && o_ready;
        out_taken <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && i_valid && o_ready)
            log_expected.push_back(log2_of(i_value_bits));
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
                // still waiting, hold payload
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (arg_queue.size() > 0) begin
                i_value_bits <= arg_queue.pop_front();
                i_valid <= 1'b1;
                send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [63:0] exp_bits;
        if (i_rst_n && o_valid && i_ready) begin
            rx_beats <= rx_beats + 1;
            if (log_expected.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, o_log_bits);
                errors <= errors + 1;
            end else begin
                exp_bits = log_expected.pop_front();
                if (exp_bits !== o_log_bits) begin
                    $display("%0t: log_bits mismatch for beat, expected %h actual %h",
                             $time, exp_bits, o_log_bits);
                    errors <= errors + 1;
                end
            end
        end
    end

    // one long receiver stall so the pipe fills and the input backs up
    always @(negedge i_clk) begin
        if (i_rst_n && !stall_done && rx_beats == 200) begin
            hold_off <= 300;
            stall_done <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off > 0) begin
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (out_taken)
                recv_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 12) : 0;
        end
    end

    initial begin
        logic [63:0] directed[$];
        directed = '{64'h0, 64'h8000_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                     64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0000,
                     64'hFFF8_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                     64'h4000_0000_0000_0000, 64'h3FE0_0000_0000_0000,
                     64'h3FFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001,
                     64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
                     64'h0010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                     64'h3FEF_FFFF_FFFF_FFFF, 64'h4008_0000_0000_0000,
                     64'h3FF6_A09E_667F_3BCD};
        foreach (directed[k]) arg_queue.push_back(directed[k]);
        for (int k = 0; k < 650; k++) arg_queue.push_back(random_arg());
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (arg_queue.size() > 0) @(posedge i_clk);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (log_expected.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && log_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
